/* src/fdn_pkg.sv */
// package for the axis fuzz / deadzone normaliser: descriptor type, codes, constants
package fdn_pkg;

	localparam int RawBits = 24;
	localparam int FieldBits = 23;
	localparam int OutBits = 16;
	localparam int DefNumAxes = 8;
	localparam int QuotBits = 16;
	localparam int ProdBits = RawBits + QuotBits;

	localparam logic signed [RawBits-1:0] OutMinRaw = -RawBits'(32768);
	localparam logic signed [RawBits-1:0] OutMaxRaw = RawBits'(32767);
	localparam logic signed [OutBits-1:0] OutMin = 16'sh8000;
	localparam logic signed [OutBits-1:0] OutMax = 16'sh7fff;
	localparam logic [QuotBits-1:0] TriggerScale = 16'd32767;
	localparam logic [QuotBits-1:0] BipolarSpan = 16'd65535;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_SAMPLE = 1'b1
	} fdn_op_t;

	typedef struct packed {
		logic inv;
		logic uni;
		logic rel;
	} fdn_mode_t;

	typedef struct packed {
		logic signed [RawBits-1:0] lo;
		logic signed [RawBits-1:0] hi;
		fdn_mode_t mode;
		logic [FieldBits-1:0] flat;
		logic [FieldBits-1:0] fuzz;
		logic signed [RawBits-1:0] last;
	} fdn_desc_t;

	localparam fdn_desc_t DescReset = '{
		lo: OutMinRaw,
		hi: OutMaxRaw,
		mode: '{inv: 1'b0, uni: 1'b0, rel: 1'b0},
		flat: '0,
		fuzz: '0,
		last: '0
	};

	typedef struct packed {
		logic en;
		fdn_desc_t data;
	} fdn_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_DIV,
		S_OUT
	} fdn_state_t;

endpackage

/* src/fdn_table.sv */
// per-axis descriptor memory with registered read and reset valid bits
module fdn_table #(
	parameter int NUM_AXES = fdn_pkg::DefNumAxes,
	parameter int AW = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [AW-1:0]     rd_addr,
	output fdn_pkg::fdn_desc_t rd_data,
	input  logic [AW-1:0]     wr_addr,
	input  fdn_pkg::fdn_wr_t  wr
);
	import fdn_pkg::*;

	fdn_desc_t mem_q [NUM_AXES];
	logic [NUM_AXES-1:0] valid_q;
	fdn_desc_t rd_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= wr.data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : DescReset;

endmodule

/* src/fdn_divider.sv */
// restoring divider, one quotient bit per cycle, quotient known to fit 16 bits
module fdn_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fdn_pkg::ProdBits-1:0]  num,
	input  logic [fdn_pkg::RawBits-1:0]   den,
	output logic                          done,
	output logic [fdn_pkg::QuotBits-1:0]  quot
);
	import fdn_pkg::*;

	localparam int CntBits = $clog2(QuotBits);

	logic [ProdBits-1:0] rem_q;
	logic [ProdBits-1:0] dd_q;
	logic [QuotBits-1:0] quot_q;
	logic [CntBits-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic take;

	assign take = (rem_q >= dd_q);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dd_q <= ProdBits'({den, (QuotBits-1)'(0)});
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - dd_q;
			end
			dd_q <= dd_q >> 1;
			quot_q <= {quot_q[QuotBits-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntBits'(QuotBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* src/axis_fuzz_deadzone_normaliser_top.sv */
// top level: item handshake, descriptor load and sample filter/normalise sequencer
// Each item takes one descriptor read and a read-modify-write; an absolute sample outside
// the deadzone then also takes one multiply and a bit-serial divide, while loads, relative
// samples, deadzone hits and out-of-range axes go straight from evaluation to output.
// A new item is taken once the previous one has left the sequencer, while its result may
// still wait in the output register. All axes read as the default descriptor after reset.
module axis_fuzz_deadzone_normaliser_top #(
	parameter int NUM_AXES = fdn_pkg::DefNumAxes
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic [2:0]                         axis_index,
	input  logic signed [fdn_pkg::RawBits-1:0] raw_value,
	input  logic signed [fdn_pkg::RawBits-1:0] range_min,
	input  logic signed [fdn_pkg::RawBits-1:0] range_max,
	input  logic                               is_relative,
	input  logic                               is_unipolar,
	input  logic                               is_inverted,
	input  logic                               no_deadzone,
	input  logic [fdn_pkg::FieldBits-1:0]      flat_override,
	input  logic [fdn_pkg::FieldBits-1:0]      fuzz_override,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               changed,
	output logic signed [fdn_pkg::OutBits-1:0] axis_out
);
	import fdn_pkg::*;

	localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	fdn_state_t state_q, state_nxt;
	logic accept;
	logic div_start;
	logic div_done;
	logic [QuotBits-1:0] div_q;

	logic op_q;
	logic [2:0] idx_q;
	logic idx_ok_q;
	logic signed [RawBits-1:0] raw_q, rmin_q, rmax_q;
	fdn_mode_t mode_in_q;
	logic nodz_q;
	logic [FieldBits-1:0] fo_q, zo_q;

	fdn_desc_t ent;
	fdn_wr_t wr;

	logic [RawBits-1:0] d_q;
	logic [RawBits-1:0] range_q;
	logic uni_q, inv_q;
	logic ch_q;
	logic signed [OutBits-1:0] res_q;
	logic out_valid_q, changed_q;
	logic signed [OutBits-1:0] axis_out_q;

	assign accept = in_valid && in_ready;

	fdn_table #(.NUM_AXES(NUM_AXES), .AW(AW)) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(AW'(axis_index)),
		.rd_data(ent),
		.wr_addr(AW'(idx_q)),
		.wr(wr)
	);

	// load path
	logic signed [RawBits-1:0] ld_lo, ld_hi;
	logic [RawBits-1:0] ld_range;
	fdn_desc_t ld_desc;
	// sample path
	logic signed [RawBits:0] dif;
	logic [RawBits-1:0] absd;
	logic ch_abs, ch;
	logic signed [RawBits-1:0] rc, ru;
	logic signed [RawBits:0] sum_w;
	logic [RawBits-1:0] range_e, d_e;
	logic signed [RawBits+1:0] off, flat_s;
	logic dz_hit;
	logic signed [OutBits-1:0] relv;
	fdn_desc_t smp_desc;
	logic [ProdBits-1:0] prod;
	logic signed [OutBits-1:0] scaled;

	always_comb begin
		ld_lo = rmin_q;
		ld_hi = rmax_q;
		if (rmax_q <= rmin_q) begin
			ld_lo = OutMinRaw;
			ld_hi = OutMaxRaw;
		end
		ld_range = RawBits'($signed({ld_hi[RawBits-1], ld_hi}) - $signed({ld_lo[RawBits-1], ld_lo}));
		ld_desc.lo = ld_lo;
		ld_desc.hi = ld_hi;
		ld_desc.mode = mode_in_q;
		ld_desc.flat = nodz_q ? '0 : ((fo_q != '0) ? fo_q : FieldBits'(ld_range >> 4));
		ld_desc.fuzz = (zo_q != '0) ? zo_q : FieldBits'(ld_range >> 8);
		if (mode_in_q.rel) begin
			ld_desc.flat = '0;
			ld_desc.fuzz = '0;
		end
		ld_desc.last = mode_in_q.uni ? ld_lo
			: RawBits'($signed({ld_lo[RawBits-1], ld_lo}) + $signed({2'b00, ld_range[RawBits-1:1]}));
	end

	always_comb begin
		dif = $signed({raw_q[RawBits-1], raw_q}) - $signed({ent.last[RawBits-1], ent.last});
		absd = dif[RawBits] ? RawBits'(-dif) : dif[RawBits-1:0];
		ch_abs = (absd != '0) &&
			!((ent.fuzz != '0) && (absd < {1'b0, ent.fuzz[FieldBits-1:1]}));
		ch = ent.mode.rel ? (raw_q != '0) : ch_abs;
		smp_desc = ent;
		if (ent.mode.rel || ch_abs) begin
			smp_desc.last = raw_q;
		end

		rc = raw_q;
		if (raw_q < ent.lo) begin
			rc = ent.lo;
		end else if (raw_q > ent.hi) begin
			rc = ent.hi;
		end
		range_e = RawBits'($signed({ent.hi[RawBits-1], ent.hi}) - $signed({ent.lo[RawBits-1], ent.lo}));
		sum_w = $signed({ent.hi[RawBits-1], ent.hi}) + $signed({ent.lo[RawBits-1], ent.lo})
			- $signed({rc[RawBits-1], rc});
		ru = (ent.mode.uni && ent.mode.inv) ? sum_w[RawBits-1:0] : rc;
		d_e = RawBits'($signed({ru[RawBits-1], ru}) - $signed({ent.lo[RawBits-1], ent.lo}));
		off = $signed({{2{rc[RawBits-1]}}, rc}) - $signed({{2{ent.lo[RawBits-1]}}, ent.lo})
			- $signed({3'b000, range_e[RawBits-1:1]});
		flat_s = $signed({3'b000, ent.flat});
		if (ent.mode.uni) begin
			dz_hit = (ent.flat != '0) && (d_e < {1'b0, ent.flat});
		end else begin
			dz_hit = (ent.flat != '0) && (off > -flat_s) && (off < flat_s);
		end

		if (rc < OutMinRaw) begin
			relv = OutMin;
		end else if (rc > OutMaxRaw) begin
			relv = OutMax;
		end else begin
			relv = rc[OutBits-1:0];
		end
		if (ent.mode.inv) begin
			relv = (relv == OutMin) ? OutMax : -relv;
		end
	end

	always_comb begin
		prod = ProdBits'(d_q) * ProdBits'(uni_q ? TriggerScale : BipolarSpan);
		if (uni_q) begin
			scaled = $signed(div_q);
		end else begin
			scaled = $signed({~div_q[QuotBits-1], div_q[QuotBits-2:0]});
			if (inv_q) begin
				scaled = (scaled == OutMin) ? OutMax : -scaled;
			end
		end
	end

	fdn_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(prod),
		.den(range_q),
		.done(div_done),
		.quot(div_q)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				if (!idx_ok_q || op_q == OP_LOAD || ent.mode.rel || dz_hit) begin
					state_nxt = S_OUT;
				end else begin
					state_nxt = S_MUL;
				end
			end
			S_MUL: state_nxt = S_DIV;
			S_DIV: begin
				if (div_done) begin
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		div_start = (state_q == S_MUL);
		wr.en = (state_q == S_EVAL) && idx_ok_q;
		wr.data = (op_q == OP_LOAD) ? ld_desc : smp_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			idx_q <= axis_index;
			idx_ok_q <= (32'(axis_index) < NUM_AXES);
			raw_q <= raw_value;
			rmin_q <= range_min;
			rmax_q <= range_max;
			mode_in_q <= '{inv: is_inverted, uni: is_unipolar, rel: is_relative};
			nodz_q <= no_deadzone;
			fo_q <= flat_override;
			zo_q <= fuzz_override;
		end
		if (state_q == S_EVAL) begin
			d_q <= d_e;
			range_q <= range_e;
			uni_q <= ent.mode.uni;
			inv_q <= ent.mode.inv;
			if (!idx_ok_q || op_q == OP_LOAD) begin
				ch_q <= 1'b0;
				res_q <= '0;
			end else begin
				ch_q <= ch;
				res_q <= ent.mode.rel ? relv : '0;
			end
		end
		if (state_q == S_DIV && div_done) begin
			res_q <= scaled;
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			changed_q <= ch_q;
			axis_out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign changed = changed_q;
	assign axis_out = axis_out_q;

`ifndef SYNTH
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EVAL)
		else $error("accepted item did not enter evaluation");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");
	a_write_eval: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_EVAL && !in_ready))
		else $error("descriptor written outside evaluation");
`endif

endmodule

/* dv/tb_axis_fuzz_deadzone_normaliser_top.sv */
// testbench for the axis fuzz / deadzone normaliser: directed and random items checked against a predictor
module tb_axis_fuzz_deadzone_normaliser_top;
	import fdn_pkg::*;

	typedef struct {
		fdn_op_t op;
		logic [2:0] axis;
		logic signed [RawBits-1:0] raw;
		logic signed [RawBits-1:0] lo;
		logic signed [RawBits-1:0] hi;
		logic rel;
		logic uni;
		logic inv;
		logic nodz;
		logic [FieldBits-1:0] flat;
		logic [FieldBits-1:0] fuzz;
	} axis_item_t;

	typedef struct {
		logic chg;
		logic signed [OutBits-1:0] value;
	} axis_result_t;

	localparam int WatchdogLimit = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic [2:0] axis_index = '0;
	logic signed [RawBits-1:0] raw_value = '0;
	logic signed [RawBits-1:0] range_min = '0;
	logic signed [RawBits-1:0] range_max = '0;
	logic is_relative = 1'b0;
	logic is_unipolar = 1'b0;
	logic is_inverted = 1'b0;
	logic no_deadzone = 1'b0;
	logic [FieldBits-1:0] flat_override = '0;
	logic [FieldBits-1:0] fuzz_override = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic changed;
	logic signed [OutBits-1:0] axis_out;

	longint ax_lo [8];
	longint ax_hi [8];
	logic ax_rel [8];
	logic ax_uni [8];
	logic ax_inv [8];
	longint ax_flat [8];
	longint ax_fuzz [8];
	longint ax_last [8];

	axis_result_t expected_results [$];
	int errors = 0;
	int send_gap_max = 0;
	int sink_stall_max = 0;
	int sink_stall = 0;
	int idle_cycles = 0;

	axis_fuzz_deadzone_normaliser_top DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint clamp_l(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic signed [RawBits-1:0] to_raw(longint v);
		return RawBits'(clamp_l(v, -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1));
	endfunction

	function automatic longint scale_axis(int a, longint sample);
		longint lo, hi, span, flat, v, off;
		lo = ax_lo[a];
		hi = ax_hi[a];
		span = hi - lo;
		flat = ax_flat[a];
		if (span <= 0) span = 1;
		sample = clamp_l(sample, lo, hi);
		if (ax_rel[a]) begin
			v = clamp_l(sample, -32768, 32767);
			if (ax_inv[a]) v = (v == -32768) ? 32767 : -v;
			return v;
		end
		if (ax_uni[a]) begin
			if (ax_inv[a]) sample = hi - (sample - lo);
			if (flat != 0 && (sample - lo) < flat) return 0;
			v = ((sample - lo) * 32767) / span;
			if (v > 32767) v = 32767;
			return v;
		end
		off = sample - (lo + span / 2);
		if (flat != 0 && off > -flat && off < flat) return 0;
		v = ((sample - lo) * 65535) / span - 32768;
		v = clamp_l(v, -32768, 32767);
		if (ax_inv[a]) v = (v == -32768) ? 32767 : -v;
		return v;
	endfunction

	function automatic axis_result_t normalise_item(axis_item_t it);
		axis_result_t r;
		int a;
		longint lo, hi, span, diff, sample;
		a = it.axis;
		r.chg = 1'b0;
		r.value = '0;
		if (it.op == OP_LOAD) begin
			lo = it.lo;
			hi = it.hi;
			if (hi <= lo) begin
				lo = -32768;
				hi = 32767;
			end
			span = hi - lo;
			ax_lo[a] = lo;
			ax_hi[a] = hi;
			ax_rel[a] = it.rel;
			ax_uni[a] = it.uni;
			ax_inv[a] = it.inv;
			ax_flat[a] = it.nodz ? 0 : (it.flat != 0 ? longint'(it.flat) : span >>> 4);
			ax_fuzz[a] = (it.fuzz != 0) ? longint'(it.fuzz) : span >>> 8;
			if (it.rel) begin
				ax_flat[a] = 0;
				ax_fuzz[a] = 0;
			end
			ax_last[a] = it.uni ? lo : lo + span / 2;
		end else begin
			sample = it.raw;
			diff = sample - ax_last[a];
			if (diff < 0) diff = -diff;
			if (ax_rel[a]) begin
				ax_last[a] = sample;
				r.chg = (sample != 0);
			end else if (diff == 0 || (ax_fuzz[a] > 0 && diff < (ax_fuzz[a] >>> 1))) begin
				r.chg = 1'b0;
			end else begin
				ax_last[a] = sample;
				r.chg = 1'b1;
			end
			r.value = OutBits'(scale_axis(a, sample));
		end
		return r;
	endfunction

	task automatic send_item(axis_item_t it);
		int gap;
		gap = $urandom_range(send_gap_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation <= it.op;
		axis_index <= it.axis;
		raw_value <= it.raw;
		range_min <= it.lo;
		range_max <= it.hi;
		is_relative <= it.rel;
		is_unipolar <= it.uni;
		is_inverted <= it.inv;
		no_deadzone <= it.nodz;
		flat_override <= it.flat;
		fuzz_override <= it.fuzz;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(normalise_item(it));
		@(negedge clk);
	endtask

	function automatic axis_item_t blank_item(int a);
		axis_item_t it;
		it.op = OP_SAMPLE;
		it.axis = 3'(a);
		it.raw = '0;
		it.lo = '0;
		it.hi = '0;
		it.rel = 1'b0;
		it.uni = 1'b0;
		it.inv = 1'b0;
		it.nodz = 1'b0;
		it.flat = '0;
		it.fuzz = '0;
		return it;
	endfunction

	task automatic load_axis(int a, longint lo, longint hi, logic rel, logic uni, logic inv,
			logic nodz, longint flat, longint fuzz);
		axis_item_t it;
		it = blank_item(a);
		it.op = OP_LOAD;
		it.raw = RawBits'($urandom);
		it.lo = to_raw(lo);
		it.hi = to_raw(hi);
		it.rel = rel;
		it.uni = uni;
		it.inv = inv;
		it.nodz = nodz;
		it.flat = FieldBits'(flat);
		it.fuzz = FieldBits'(fuzz);
		send_item(it);
	endtask

	task automatic sample_axis(int a, longint v);
		axis_item_t it;
		it = blank_item(a);
		it.raw = to_raw(v);
		it.lo = RawBits'($urandom);
		it.hi = RawBits'($urandom);
		it.flat = FieldBits'($urandom);
		it.fuzz = FieldBits'($urandom);
		it.rel = 1'($urandom);
		it.uni = 1'($urandom);
		it.inv = 1'($urandom);
		it.nodz = 1'($urandom);
		send_item(it);
	endtask

	task automatic test_reset_defaults();
		send_gap_max = 0;
		sink_stall_max = 0;
		sample_axis(0, 0);
		sample_axis(1, 100);
		sample_axis(2, -8388608);
		sample_axis(3, 8388607);
	endtask

	task automatic test_load_modes();
		send_gap_max = 13;
		sink_stall_max = 13;
		load_axis(0, -1000, 1000, 0, 0, 0, 0, 0, 0);
		sample_axis(0, -1000);
		sample_axis(0, 10);
		sample_axis(0, 1000);
		load_axis(1, 0, 255, 0, 1, 0, 0, 0, 0);
		sample_axis(1, 5);
		sample_axis(1, 255);
		load_axis(2, 0, 255, 0, 1, 1, 1, 0, 0);
		sample_axis(2, 0);
		load_axis(3, -8388608, 8388607, 0, 0, 1, 0, 8388607, 8388607);
		sample_axis(3, -8388608);
		sample_axis(3, 8388607);
	endtask

	task automatic test_special_cases();
		send_gap_max = 3;
		sink_stall_max = 13;
		load_axis(4, 500, 500, 0, 0, 1, 1, 0, 0);
		sample_axis(4, -40000);
		sample_axis(4, -40000);
		load_axis(5, -8388608, 8388607, 1, 0, 1, 0, 7, 7);
		sample_axis(5, -32768);
		sample_axis(5, 0);
		sample_axis(5, 8388607);
		load_axis(6, 100, -100, 0, 0, 0, 0, 0, 40);
		sample_axis(6, 10);
		load_axis(7, -10, 10, 0, 0, 1, 1, 0, 0);
		sample_axis(7, -10);
	endtask

	task automatic test_random(int count);
		int a, kind;
		longint lo, span, flat, fuzz, v;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				send_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 13;
				sink_stall_max = ($urandom_range(2, 0) == 0) ? 0 : 13;
			end
			a = $urandom_range(7, 0);
			if ($urandom_range(9, 0) < 3) begin
				kind = $urandom_range(9, 0);
				if (kind < 5) begin
					lo = $signed($urandom_range(2000, 0)) - 1000;
					span = $urandom_range(400, 1);
				end else if (kind < 8) begin
					lo = $signed($urandom_range(200000, 0)) - 100000;
					span = $urandom_range(100000, 1);
				end else begin
					lo = longint'($signed(RawBits'($urandom)));
					span = longint'($signed(RawBits'($urandom))) - lo;
				end
				flat = ($urandom_range(1, 0) == 0) ? 0 :
					(($urandom_range(3, 0) == 0) ? longint'(FieldBits'($urandom)) :
					$urandom_range(50, 1));
				fuzz = ($urandom_range(1, 0) == 0) ? 0 :
					(($urandom_range(3, 0) == 0) ? longint'(FieldBits'($urandom)) :
					$urandom_range(30, 1));
				load_axis(a, lo, lo + span, $urandom_range(3, 0) == 0, 1'($urandom),
					1'($urandom), $urandom_range(3, 0) == 0, flat, fuzz);
			end else begin
				kind = $urandom_range(9, 0);
				if (kind < 6)
					v = ax_lo[a] + $signed($urandom_range(ax_hi[a] - ax_lo[a] + 10, 0)) - 5;
				else if (kind < 8)
					v = ax_last[a] + $signed($urandom_range(40, 0)) - 20;
				else
					v = longint'($signed(RawBits'($urandom)));
				sample_axis(a, v);
			end
		end
	endtask

	always @(negedge clk) begin
		out_ready <= (sink_stall == 0);
		if (sink_stall > 0) sink_stall <= sink_stall - 1;
	end

	always @(posedge clk) begin
		axis_result_t exp_r;
		if (arst_n) begin
			idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 :
				idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
		if (out_valid && out_ready) begin
			sink_stall <= $urandom_range(sink_stall_max, 0);
			if (expected_results.size() == 0) begin
				$error("unexpected item: changed %0d axis_out %0d", changed, axis_out);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (changed !== exp_r.chg) begin
					$error("changed: expected %0d actual %0d", exp_r.chg, changed);
					errors++;
				end
				if (axis_out !== exp_r.value) begin
					$error("axis_out: expected %0d actual %0d", exp_r.value, axis_out);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < 8; i++) begin
			ax_lo[i] = -32768;
			ax_hi[i] = 32767;
			ax_rel[i] = 1'b0;
			ax_uni[i] = 1'b0;
			ax_inv[i] = 1'b0;
			ax_flat[i] = 0;
			ax_fuzz[i] = 0;
			ax_last[i] = 0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_load_modes();
		test_special_cases();
		test_random(550);
		in_valid <= 1'b0;
		sink_stall_max = 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
